// ===== sv/tls_pkg.sv =====
// tls_pkg: shared types and constants for the text line sorter
// no dependencies
`timescale 1ns / 1ps
package tls_pkg;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [1:0] FN_LOAD   = 2'd0;
    localparam logic [1:0] FN_FINISH = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_NEXT,
        ST_KEY,
        ST_PREV_RD,
        ST_PREV,
        ST_CMP_A,
        ST_CMP_B,
        ST_CMP_C,
        ST_LINE_RD,
        ST_LINE_CAP,
        ST_EMIT
    } t_state;

endpackage

// ===== sv/tls_ram.sv =====
// tls_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
`timescale 1ns / 1ps
module tls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/text_line_sorter_unit.sv =====
// text_line_sorter_unit: loads text, splits lines, sorts them in place, streams them out
// depends on tls_pkg and tls_ram (text store and line table)
// load items: one per cycle; emit-phase items: one per cycle unless output stalls, read
// items within a line; after each line end input stalls for the line table read and
// text fetch (table read only after the last); finish: insertion sort over the line
// table, each compare reading text ram bytes via ST_CMP_A/B/C; duration depends on data
// synchronous active-low reset clears control state; ram contents stay undefined
`timescale 1ns / 1ps
module text_line_sorter_unit #(
    parameter int MAX_BYTES = 16384,
    parameter int MAX_LINES = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_byte_value,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_line_end,
    output logic       o_all_done,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [0:0] i_cfg_data
);
    import tls_pkg::*;

    localparam int AW = $clog2(MAX_BYTES);
    localparam int LW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int EW = 2 * AW;
    localparam logic [AW-1:0] BYTE_LIMIT = AW'(MAX_BYTES - 1);
    localparam logic [CW-1:0] LINE_LIMIT = CW'(MAX_LINES);

    t_state r_state, n_state;
    logic [AW-1:0] r_count, n_count, r_cls, n_cls, r_last_len, n_last_len;
    logic [CW-1:0] r_kept, n_kept, r_idx, n_idx, r_i, n_i, r_j, n_j;
    logic          r_ended, n_ended, r_rev, n_rev, r_cfg_rev;
    logic [7:0]    r_prev_byte, n_prev_byte, r_abyte, n_abyte;
    logic [AW-1:0] r_ptr, n_ptr, r_cur_start, n_cur_start, r_cur_len, n_cur_len;
    logic [AW-1:0] r_k, n_k, r_n, n_n;
    logic [EW-1:0] r_key, n_key, r_pe, n_pe;
    logic          r_out_valid, n_out_valid, r_out_bv, n_out_bv;
    logic          r_out_le, n_out_le, r_out_done, n_out_done;
    logic [7:0]    r_out_byte, n_out_byte;

    logic          t_we, l_we;
    logic [AW-1:0] t_waddr, t_raddr;
    logic [7:0]    t_rdata;
    logic [LW-1:0] l_waddr, l_raddr;
    logic [EW-1:0] l_wdata, l_rdata;

    logic          acc, is_load, is_finish, is_read;
    logic          cmp_dec, cmp_lt, cmp_gt, cmp_mv;
    logic [AW-1:0] pe_start, pe_len, key_start, key_len;

    tls_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_text (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(i_byte_value),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    tls_ram #(.WIDTH(EW), .DEPTH(MAX_LINES)) u_lines (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(l_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign acc       = i_in_valid && o_in_ready;
    assign is_load   = acc && (i_func == FN_LOAD);
    assign is_finish = acc && (i_func == FN_FINISH);
    assign is_read   = acc && (i_func == FN_READ);

    assign pe_start  = r_pe[EW-1:AW];
    assign pe_len    = r_pe[AW-1:0];
    assign key_start = r_key[EW-1:AW];
    assign key_len   = r_key[AW-1:0];

    always_comb begin
        cmp_dec = 1'b0;
        cmp_lt  = 1'b0;
        cmp_gt  = 1'b0;
        if (r_state == ST_CMP_A && r_k == r_n) begin
            cmp_dec = 1'b1;
            cmp_lt  = pe_len < key_len;
            cmp_gt  = pe_len > key_len;
        end else if (r_state == ST_CMP_C && r_abyte != t_rdata) begin
            cmp_dec = 1'b1;
            cmp_lt  = r_abyte < t_rdata;
            cmp_gt  = r_abyte > t_rdata;
        end
    end
    assign cmp_mv = r_rev ? cmp_lt : cmp_gt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD:      if (is_finish) n_state = ST_SORT_NEXT;
            ST_SORT_NEXT: n_state = (r_i >= r_kept) ? ST_LINE_RD : ST_KEY;
            ST_KEY:       n_state = ST_PREV_RD;
            ST_PREV_RD:   n_state = (r_j == '0) ? ST_SORT_NEXT : ST_PREV;
            ST_PREV:      n_state = ST_CMP_A;
            ST_CMP_A: begin
                if (cmp_dec) n_state = cmp_mv ? ST_PREV_RD : ST_SORT_NEXT;
                else n_state = ST_CMP_B;
            end
            ST_CMP_B:     n_state = ST_CMP_C;
            ST_CMP_C: begin
                if (cmp_dec) n_state = cmp_mv ? ST_PREV_RD : ST_SORT_NEXT;
                else n_state = ST_CMP_A;
            end
            ST_LINE_RD:   n_state = (r_idx < r_kept) ? ST_LINE_CAP : ST_EMIT;
            ST_LINE_CAP:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (is_read && r_idx < r_kept && r_ptr >= r_cur_len) n_state = ST_LINE_RD;
            end
            default:      n_state = ST_LOAD;
        endcase
    end

    // outputs and datapath
    always_comb begin
        logic [AW-1:0] c_len, c_last;
        logic [CW-1:0] c_kept;
        logic          c_close;

        o_in_ready = 1'b0;
        t_we = 1'b0; t_waddr = r_count; t_raddr = '0;
        l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = '0;
        n_count = r_count; n_cls = r_cls; n_last_len = r_last_len;
        n_kept = r_kept; n_idx = r_idx; n_i = r_i; n_j = r_j;
        n_ended = r_ended; n_rev = r_rev; n_prev_byte = r_prev_byte;
        n_abyte = r_abyte; n_ptr = r_ptr; n_cur_start = r_cur_start;
        n_cur_len = r_cur_len; n_k = r_k; n_n = r_n; n_key = r_key; n_pe = r_pe;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_byte = r_out_byte; n_out_bv = r_out_bv;
        n_out_le = r_out_le; n_out_done = r_out_done;

        c_len = r_count - r_cls;
        if (c_len != '0 && r_prev_byte == CH_CR) c_len = c_len - 1'b1;
        c_close = 1'b0;
        c_kept = r_kept;
        c_last = r_last_len;

        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (is_load && !r_ended && r_count < BYTE_LIMIT) begin
                    t_we = 1'b1;
                    n_prev_byte = i_byte_value;
                    n_count = r_count + 1'b1;
                    if (i_byte_value == 8'd0 || i_byte_value == CH_LF) c_close = 1'b1;
                    if (i_byte_value == 8'd0) n_ended = 1'b1;
                end
                if (is_finish && !r_ended) begin
                    c_close = 1'b1;
                    n_ended = 1'b1;
                end
                c_kept = r_kept;
                c_last = r_last_len;
                if (c_close) begin
                    n_cls = r_count + 1'b1;
                    if (r_kept < LINE_LIMIT) begin
                        l_we = 1'b1;
                        l_waddr = r_kept[LW-1:0];
                        l_wdata = {r_cls, c_len};
                        c_kept = r_kept + 1'b1;
                        c_last = c_len;
                    end
                end
                n_kept = c_kept;
                n_last_len = c_last;
                if (is_finish) begin
                    if (c_kept != '0 && c_last == '0) n_kept = c_kept - 1'b1;
                    n_rev = r_cfg_rev;
                    n_i = CW'(1);
                    n_idx = '0;
                    n_ptr = '0;
                end
            end
            ST_SORT_NEXT: l_raddr = r_i[LW-1:0];
            ST_KEY: begin
                n_key = l_rdata;
                n_j = r_i;
            end
            ST_PREV_RD: begin
                if (r_j == '0) begin
                    l_we = 1'b1;
                    l_waddr = '0;
                    l_wdata = r_key;
                    n_i = r_i + 1'b1;
                end else begin
                    l_raddr = LW'(r_j - 1'b1);
                end
            end
            ST_PREV: begin
                n_pe = l_rdata;
                n_k = '0;
                n_n = (l_rdata[AW-1:0] < key_len) ? l_rdata[AW-1:0] : key_len;
            end
            ST_CMP_A, ST_CMP_C: begin
                if (r_state == ST_CMP_A) t_raddr = pe_start + r_k;
                if (r_state == ST_CMP_C && !cmp_dec) n_k = r_k + 1'b1;
                if (cmp_dec) begin
                    l_we = 1'b1;
                    l_waddr = r_j[LW-1:0];
                    if (cmp_mv) begin
                        l_wdata = r_pe;
                        n_j = r_j - 1'b1;
                    end else begin
                        l_wdata = r_key;
                        n_i = r_i + 1'b1;
                    end
                end
            end
            ST_CMP_B: begin
                n_abyte = t_rdata;
                t_raddr = key_start + r_k;
            end
            ST_LINE_RD: l_raddr = r_idx[LW-1:0];
            ST_LINE_CAP: begin
                n_cur_start = l_rdata[EW-1:AW];
                n_cur_len = l_rdata[AW-1:0];
                n_ptr = '0;
                t_raddr = l_rdata[EW-1:AW];
            end
            ST_EMIT: begin
                o_in_ready = !r_out_valid || i_out_ready;
                if (is_read) begin
                    n_out_valid = 1'b1;
                    n_out_byte = 8'd0;
                    n_out_bv = 1'b0;
                    n_out_le = 1'b0;
                    n_out_done = 1'b0;
                    if (r_idx >= r_kept) begin
                        n_out_done = 1'b1;
                    end else if (r_ptr < r_cur_len) begin
                        n_out_byte = t_rdata;
                        n_out_bv = 1'b1;
                        n_ptr = r_ptr + 1'b1;
                    end else begin
                        n_out_le = 1'b1;
                        n_idx = r_idx + 1'b1;
                        n_ptr = '0;
                    end
                end
                t_raddr = r_cur_start + n_ptr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_cls <= '0;
            r_last_len <= '0;
            r_kept <= '0;
            r_idx <= '0;
            r_ptr <= '0;
            r_ended <= 1'b0;
            r_rev <= 1'b0;
            r_cfg_rev <= 1'b0;
            r_prev_byte <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cls <= n_cls;
            r_last_len <= n_last_len;
            r_kept <= n_kept;
            r_idx <= n_idx;
            r_ptr <= n_ptr;
            r_ended <= n_ended;
            r_rev <= n_rev;
            if (i_cfg_valid) r_cfg_rev <= i_cfg_data[0];
            r_prev_byte <= n_prev_byte;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
        r_abyte <= n_abyte;
        r_cur_start <= n_cur_start;
        r_cur_len <= n_cur_len;
        r_k <= n_k;
        r_n <= n_n;
        r_key <= n_key;
        r_pe <= n_pe;
        r_out_byte <= n_out_byte;
        r_out_bv <= n_out_bv;
        r_out_le <= n_out_le;
        r_out_done <= n_out_done;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_out_bv;
    assign o_line_end   = r_out_le;
    assign o_all_done   = r_out_done;
endmodule

// ===== sv/tls_checker.sv =====
// tls_checker: port-level assertions for text_line_sorter_unit
// bound to the top level; no other dependencies
`timescale 1ns / 1ps
module tls_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_line_end,
    input logic       o_all_done
);
    // a result carries exactly one kind
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot({o_byte_valid, o_line_end, o_all_done}))
        else $error("result kind not one-hot");

    // no byte means a zero byte field
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> (o_out_byte == 8'd0))
        else $error("byte field set without byte");

    // a new result only follows an input transfer
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready))
        else $error("result without input transfer");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_out_byte) && $stable(o_line_end) && $stable(o_all_done)))
        else $error("stalled result changed");
endmodule

bind text_line_sorter_unit tls_checker u_tls_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_byte(o_out_byte),
    .o_byte_valid(o_byte_valid), .o_line_end(o_line_end), .o_all_done(o_all_done)
);
